// ----- sv/ihst_pkg.sv -----
// Shared types and codes for the interrupt handler slot table.
package ihst_pkg;

    // Default table depth and the cap on matches per dispatch
    localparam int NUM_SLOTS_DEF = 16;
    localparam int RESULT_CAP    = 16;
    localparam int CAP_W         = $clog2(RESULT_CAP + 1);

    // Command codes
    localparam logic [1:0] CMD_REGISTER = 2'd0;
    localparam logic [1:0] CMD_REMOVE   = 2'd1;
    localparam logic [1:0] CMD_DISPATCH = 2'd2;

    // Result kinds
    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_MATCH = 1'b1;

    // Input word
    typedef struct packed {
        logic [1:0]  command;
        logic [14:0] int_mask;
        logic [3:0]  slot_index;
        logic [31:0] handler_address;
        logic [31:0] context_word;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic        kind;
        logic [3:0]  slot_number;
        logic        table_full;
        logic [31:0] match_address;
        logic [31:0] match_context;
        logic        last;
    } t_out_word;

    // One stored slot entry
    typedef struct packed {
        logic [14:0] mask;
        logic [31:0] handler;
        logic [31:0] ctx;
    } t_slot_entry;

endpackage

// ----- sv/ihst_slot_mem.sv -----
// Slot store: one write port, one read port with registered read data.
module ihst_slot_mem import ihst_pkg::*; #(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    parameter int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [IDX_W-1:0]  i_wr_addr,
    input  t_slot_entry       i_wr_data,
    input  logic [IDX_W-1:0]  i_rd_addr,
    output t_slot_entry       o_rd_data
);

    t_slot_entry r_mem [NUM_SLOTS];
    t_slot_entry r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/interrupt_handler_slot_table.sv -----
// Interrupt handler slot table: top level with the slot scan sequencer.
// Remove and unused commands complete without leaving idle; register scans one slot per
// cycle for the first free one, then gives its reply through a register.
// Dispatch compares one slot per cycle through the single read port of the slot
// store; matches leave at most one per cycle.
// Results are strobed for one cycle; the receiver cannot stall them.
// Reset (synchronous, active low) frees all slots and idles the sequencer.
module interrupt_handler_slot_table import ihst_pkg::*; #(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_cmd,
    output logic      o_valid,
    output t_out_word o_res
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam int XW    = (CNT_W > 4) ? CNT_W : 4;

    // Sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_REG   = 2'd1;
    localparam logic [1:0] S_DISP  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]           r_state, n_state;
    t_in_word             r_cmd, n_cmd;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic [NUM_SLOTS-1:0] r_active, n_active;
    logic                 r_p_vld, n_p_vld;
    logic [IDX_W-1:0]     r_p_idx, n_p_idx;
    logic                 r_p_act, n_p_act;
    logic                 r_held_vld, n_held_vld;
    logic [IDX_W-1:0]     r_held_idx, n_held_idx;
    logic [31:0]          r_held_addr, n_held_addr;
    logic [31:0]          r_held_ctx, n_held_ctx;
    logic [CAP_W-1:0]     r_found, n_found;
    logic                 r_out_vld, n_out_vld;
    t_out_word            r_out, n_out;

    logic                 accept;
    logic [XW-1:0]        rm_idx;
    logic                 issue;
    logic                 hit;
    logic                 end_scan;
    logic                 wr_en;
    t_slot_entry          wr_data;
    t_slot_entry          rd_data;

    assign accept = start && (r_state == S_IDLE);
    assign rm_idx = XW'(i_cmd.slot_index);

    // Slot store
    assign wr_data.mask    = r_cmd.int_mask;
    assign wr_data.handler = r_cmd.handler_address;
    assign wr_data.ctx     = r_cmd.context_word;
    assign wr_en = (r_state == S_REG) && !r_active[r_idx[IDX_W-1:0]];

    ihst_slot_mem #(
        .NUM_SLOTS (NUM_SLOTS),
        .IDX_W     (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_idx[IDX_W-1:0]),
        .i_wr_data (wr_data),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    // Shared compare: one slot's mask against the pending bits
    assign issue = (r_state == S_DISP) && (r_idx < CNT_W'(NUM_SLOTS));
    assign hit   = r_p_vld && r_p_act && ((rd_data.mask & r_cmd.int_mask) != '0);
    assign end_scan = (r_p_vld && (r_p_idx == IDX_W'(NUM_SLOTS - 1)))
                   || (hit && (r_found == CAP_W'(RESULT_CAP - 1)));

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_active    = r_active;
        n_p_vld     = 1'b0;
        n_p_idx     = r_idx[IDX_W-1:0];
        n_p_act     = 1'b0;
        n_held_vld  = r_held_vld;
        n_held_idx  = r_held_idx;
        n_held_addr = r_held_addr;
        n_held_ctx  = r_held_ctx;
        n_found     = r_found;
        n_out_vld   = 1'b0;
        n_out       = r_out;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd      = i_cmd;
                    n_idx      = '0;
                    n_found    = '0;
                    n_held_vld = 1'b0;
                    case (i_cmd.command)
                        CMD_REGISTER: n_state = S_REG;
                        CMD_DISPATCH: n_state = S_DISP;
                        CMD_REMOVE: begin
                            if (rm_idx < XW'(NUM_SLOTS)) begin
                                n_active[rm_idx[IDX_W-1:0]] = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_REG: begin
                // take the first free slot, or report full after the last one
                if (!r_active[r_idx[IDX_W-1:0]]) begin
                    n_active[r_idx[IDX_W-1:0]] = 1'b1;
                    n_out_vld         = 1'b1;
                    n_out             = '0;
                    n_out.kind        = KIND_REPLY;
                    n_out.slot_number = 4'(r_idx);
                    n_out.last        = 1'b1;
                    n_state           = S_IDLE;
                end else if (r_idx == CNT_W'(NUM_SLOTS - 1)) begin
                    n_out_vld        = 1'b1;
                    n_out            = '0;
                    n_out.kind       = KIND_REPLY;
                    n_out.table_full = 1'b1;
                    n_out.last       = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DISP: begin
                // read stage
                if (issue) begin
                    n_p_vld = 1'b1;
                    n_p_act = r_active[r_idx[IDX_W-1:0]];
                    n_idx   = r_idx + 1'b1;
                end
                // compare stage: a new hit releases the one held before it
                if (hit) begin
                    if (r_held_vld) begin
                        n_out_vld           = 1'b1;
                        n_out.kind          = KIND_MATCH;
                        n_out.slot_number   = 4'(r_held_idx);
                        n_out.table_full    = 1'b0;
                        n_out.match_address = r_held_addr;
                        n_out.match_context = r_held_ctx;
                        n_out.last          = 1'b0;
                    end
                    n_held_vld  = 1'b1;
                    n_held_idx  = r_p_idx;
                    n_held_addr = rd_data.handler;
                    n_held_ctx  = rd_data.ctx;
                    n_found     = r_found + 1'b1;
                end
                if (end_scan) begin
                    n_p_vld = 1'b0;
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                // held match is the final one
                if (r_held_vld) begin
                    n_out_vld           = 1'b1;
                    n_out.kind          = KIND_MATCH;
                    n_out.slot_number   = 4'(r_held_idx);
                    n_out.table_full    = 1'b0;
                    n_out.match_address = r_held_addr;
                    n_out.match_context = r_held_ctx;
                    n_out.last          = 1'b1;
                end
                n_held_vld = 1'b0;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_active   <= '0;
            r_p_vld    <= 1'b0;
            r_held_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_idx      <= '0;
            r_found    <= '0;
        end else begin
            r_state    <= n_state;
            r_active   <= n_active;
            r_p_vld    <= n_p_vld;
            r_held_vld <= n_held_vld;
            r_out_vld  <= n_out_vld;
            r_idx      <= n_idx;
            r_found    <= n_found;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_p_idx     <= n_p_idx;
        r_p_act     <= n_p_act;
        r_held_idx  <= n_held_idx;
        r_held_addr <= n_held_addr;
        r_held_ctx  <= n_held_ctx;
        r_out       <= n_out;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_out_vld;
    assign o_res   = r_out;

endmodule

// ----- sv/ihst_checker.sv -----
// Port-level checks for the interrupt handler slot table, bound to the top level.
module ihst_checker import ihst_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_in_word  i_cmd,
    input logic      o_valid,
    input t_out_word o_res
);

    // a register reply is always a single, final word
    a_reply_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_res.kind == KIND_REPLY)) |-> o_res.last)
        else $error("register reply without last");

    // a full reply carries slot zero and no stored data
    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_res.kind == KIND_REPLY) && o_res.table_full)
        |-> ((o_res.slot_number == 4'd0) && (o_res.match_address == 32'd0)
             && (o_res.match_context == 32'd0)))
        else $error("full reply carries data");

    // dispatch matches never flag a full table
    a_match_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_res.kind == KIND_MATCH)) |-> !o_res.table_full)
        else $error("dispatch match with full flag");

    // remove finishes in the cycle it is taken
    a_remove_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd.command == CMD_REMOVE)) |=> !busy)
        else $error("remove left the block busy");

endmodule

bind interrupt_handler_slot_table ihst_checker u_ihst_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_cmd   (i_cmd),
    .o_valid (o_valid),
    .o_res   (o_res)
);
